// ----- design/dkd_pkg.sv -----
package dkd_pkg;

    localparam int TABLE_SLOTS_DEF = 2048;
    localparam int QUEUE_DEPTH     = 2;
    localparam int KEY_W           = 64;
    localparam int HASH_W_MAX      = 16;
    localparam int SLOT_FIELD_W    = 11;

    localparam logic [31:0] HASH_MULT = 32'd2654435761;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_CLEAR  = 1'b1
    } t_action;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_ZERO_KEY  = 3'd3,
        ST_CLEARED   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_ZERO   = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_cmd_kind;

    typedef enum logic [1:0] {
        BS_INIT  = 2'd0,
        BS_IDLE  = 2'd1,
        BS_PROBE = 2'd2,
        BS_CLEAR = 2'd3
    } t_back_state;

    typedef struct packed {
        t_action            action;
        logic [KEY_W-1:0]   key;
    } t_item;

    typedef struct packed {
        t_status                  status;
        logic [SLOT_FIELD_W-1:0]  slot;
    } t_result;

    typedef struct packed {
        t_cmd_kind              kind;
        logic [KEY_W-1:0]       key;
        logic [HASH_W_MAX-1:0]  hash;
    } t_cmd;

endpackage

// ----- design/dkd_fifo.sv -----
module dkd_fifo
    import dkd_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : PTR_W'(r_wr + PTR_W'(1));
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : PTR_W'(r_rd + PTR_W'(1));
        end
        if (do_push && !do_pop) begin
            n_cnt = CNT_W'(r_cnt + CNT_W'(1));
        end else if (do_pop && !do_push) begin
            n_cnt = CNT_W'(r_cnt - CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- design/dkd_front.sv -----
module dkd_front
    import dkd_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_hold,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_cmd_push,
    output t_cmd  o_cmd,
    input  logic  i_cmd_full
);

    localparam int SLOT_W = $clog2(TABLE_SLOTS);

    logic                  r_valid;
    t_item                 r_item;
    logic                  accept;
    logic [SLOT_W-1:0]     hash_src;
    logic [2*SLOT_W-1:0]   product;

    assign o_full     = i_hold || (r_valid && i_cmd_full);
    assign accept     = i_push && !o_full;
    assign o_cmd_push = r_valid && !i_cmd_full;

    // Only the low bits of the product reach the slot index, so a narrow
    // multiply of key bits from bit 4 upward gives the same home slot.
    assign hash_src = r_item.key[4 +: SLOT_W];
    assign product  = {SLOT_W'(0), hash_src} * {SLOT_W'(0), HASH_MULT[SLOT_W-1:0]};

    always_comb begin
        o_cmd.key  = r_item.key;
        o_cmd.hash = HASH_W_MAX'(product[SLOT_W-1:0]);
        if (r_item.action == ACT_CLEAR) begin
            o_cmd.kind = CMD_CLEAR;
        end else if (r_item.key == '0) begin
            o_cmd.kind = CMD_ZERO;
        end else begin
            o_cmd.kind = CMD_INSERT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_cmd_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

endmodule

// ----- design/dkd_back.sv -----
module dkd_back
    import dkd_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  logic    i_cmd_empty,
    output logic    o_cmd_pop,
    output logic    o_res_push,
    output t_result o_res,
    input  logic    i_res_full,
    output logic    o_init
);

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_SLOTS - 1);

    t_back_state       r_state;
    t_back_state       n_state;
    logic [SLOT_W-1:0] r_pos;
    logic [SLOT_W-1:0] n_pos;
    logic [SLOT_W-1:0] r_cnt;
    logic [SLOT_W-1:0] n_cnt;
    logic [KEY_W-1:0]  r_key;
    logic [KEY_W-1:0]  r_rdata;
    logic [KEY_W-1:0]  r_mem [TABLE_SLOTS];
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [KEY_W-1:0]  wr_data;
    logic [SLOT_W-1:0] pos_inc;

    assign pos_inc = SLOT_W'(r_pos + SLOT_W'(1));
    assign o_init  = (r_state == BS_INIT);

    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_cnt      = r_cnt;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '{status: ST_INSERTED, slot: '0};
        rd_en      = 1'b0;
        rd_addr    = r_pos;
        wr_en      = 1'b0;
        wr_data    = '0;
        unique case (r_state)
            BS_INIT: begin
                wr_en = 1'b1;
                n_pos = pos_inc;
                if (r_pos == SLOT_LAST) begin
                    n_state = BS_IDLE;
                end
            end
            BS_IDLE: begin
                if (!i_cmd_empty && !i_res_full) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.kind)
                        CMD_CLEAR: begin
                            n_pos   = '0;
                            n_state = BS_CLEAR;
                        end
                        CMD_INSERT: begin
                            rd_en   = 1'b1;
                            rd_addr = i_cmd.hash[SLOT_W-1:0];
                            n_pos   = i_cmd.hash[SLOT_W-1:0];
                            n_cnt   = '0;
                            n_state = BS_PROBE;
                        end
                        default: begin
                            o_res_push   = 1'b1;
                            o_res.status = ST_ZERO_KEY;
                        end
                    endcase
                end
            end
            BS_PROBE: begin
                if (r_rdata == '0) begin
                    if (!i_res_full) begin
                        wr_en        = 1'b1;
                        wr_data      = r_key;
                        o_res_push   = 1'b1;
                        o_res.status = ST_INSERTED;
                        o_res.slot   = SLOT_FIELD_W'(r_pos);
                        n_state      = BS_IDLE;
                    end
                end else if (r_rdata == r_key) begin
                    if (!i_res_full) begin
                        o_res_push   = 1'b1;
                        o_res.status = ST_DUPLICATE;
                        o_res.slot   = SLOT_FIELD_W'(r_pos);
                        n_state      = BS_IDLE;
                    end
                end else if (r_cnt == SLOT_LAST) begin
                    if (!i_res_full) begin
                        o_res_push   = 1'b1;
                        o_res.status = ST_FULL;
                        n_state      = BS_IDLE;
                    end
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = pos_inc;
                    n_pos   = pos_inc;
                    n_cnt   = SLOT_W'(r_cnt + SLOT_W'(1));
                end
            end
            BS_CLEAR: begin
                if (r_pos != SLOT_LAST) begin
                    wr_en = 1'b1;
                    n_pos = pos_inc;
                end else if (!i_res_full) begin
                    wr_en        = 1'b1;
                    o_res_push   = 1'b1;
                    o_res.status = ST_CLEARED;
                    n_pos        = '0;
                    n_state      = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_INIT;
            r_pos   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_key <= i_cmd.key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_pos] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    a_no_pop_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_INIT) |-> !o_cmd_pop)
        else $error("A command was taken during the clearing pass.");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("A result was pushed into a full queue.");

    a_no_zero_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && (r_state == BS_PROBE)) |-> (wr_data != '0))
        else $error("A zero key was written into the store.");

    a_probe_starts_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == BS_IDLE) && (n_state == BS_PROBE)) |=> (r_cnt == '0))
        else $error("The probe count did not restart for a new key.");

endmodule

// ----- design/duplicate_key_detector_unit.sv -----
// Checks each 64-bit key against an open-addressing set of TABLE_SLOTS entries held in one
// single-port memory, reporting inserted, duplicate, table full, zero key ignored or
// cleared, one result per beat and in order. An insert passes through the input register
// and the command queue, issues its home-slot read and then probes one slot at a time
// until it finds an empty slot or its own key, or has tried every slot. The memory port
// does one read or one write a cycle. A clear sweeps the memory one entry a cycle, the
// last entry waiting for room in the result queue. After reset the same sweep runs, and
// full stays high until it has finished.
module duplicate_key_detector_unit
    import dkd_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
    parameter int CMD_DEPTH   = QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    push,
    input  t_item   i_item,
    output logic    full,
    output logic    empty,
    input  logic    pop,
    output t_result o_result
);

    localparam int CMD_W = $bits(t_cmd);
    localparam int RES_W = $bits(t_result);

    logic             init;
    logic             cmd_push;
    t_cmd             cmd_in;
    logic             cmd_full;
    logic [CMD_W-1:0] cmd_q;
    logic             cmd_empty;
    logic             cmd_pop;
    logic             res_push;
    t_result          res_in;
    logic             res_full;
    logic [RES_W-1:0] res_q;

    dkd_front #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_hold     (init),
        .i_push     (push),
        .i_item     (i_item),
        .o_full     (full),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in),
        .i_cmd_full (cmd_full)
    );

    dkd_fifo #(
        .W    (CMD_W),
        .DEPTH(CMD_DEPTH)
    ) u_cmd_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (cmd_push),
        .i_data (cmd_in),
        .o_full (cmd_full),
        .i_pop  (cmd_pop),
        .o_data (cmd_q),
        .o_empty(cmd_empty)
    );

    dkd_back #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (t_cmd'(cmd_q)),
        .i_cmd_empty(cmd_empty),
        .o_cmd_pop  (cmd_pop),
        .o_res_push (res_push),
        .o_res      (res_in),
        .i_res_full (res_full),
        .o_init     (init)
    );

    dkd_fifo #(
        .W    (RES_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_push),
        .i_data (res_in),
        .o_full (res_full),
        .i_pop  (pop),
        .o_data (res_q),
        .o_empty(empty)
    );

    assign o_result = t_result'(res_q);

endmodule

// ----- tb/key_set_monitor.sv -----
module key_set_monitor
    import dkd_pkg::*;
#(
    parameter int SLOTS = TABLE_SLOTS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  logic    i_full,
    input  t_item   i_item,
    input  logic    i_empty,
    input  logic    i_pop,
    input  t_result i_result,
    output int      o_mismatches,
    output int      o_pending,
    output int      o_checked,
    output int      o_duplicates,
    output int      o_full_reports
);

    logic [KEY_W-1:0] stored_keys [SLOTS];
    t_result          awaited_results [$];
    int               mismatches;
    int               checked;
    int               duplicates;
    int               full_reports;

    function automatic t_result probe_and_record(t_item beat);
        t_result          outcome;
        logic [KEY_W-1:0] product;
        int unsigned      pos;
        outcome.status = ST_ZERO_KEY;
        outcome.slot   = '0;
        if (beat.action == ACT_CLEAR) begin
            foreach (stored_keys[i]) stored_keys[i] = '0;
            outcome.status = ST_CLEARED;
            return outcome;
        end
        if (beat.key == '0) begin
            return outcome;
        end
        product = (beat.key >> 4) * {32'd0, HASH_MULT};
        pos     = product[31:0] & (SLOTS - 1);
        repeat (SLOTS) begin
            if (stored_keys[pos] == '0) begin
                stored_keys[pos] = beat.key;
                outcome.status   = ST_INSERTED;
                outcome.slot     = pos[SLOT_FIELD_W-1:0];
                return outcome;
            end
            if (stored_keys[pos] == beat.key) begin
                outcome.status = ST_DUPLICATE;
                outcome.slot   = pos[SLOT_FIELD_W-1:0];
                return outcome;
            end
            pos = (pos + 1) & (SLOTS - 1);
        end
        outcome.status = ST_FULL;
        return outcome;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result wanted;
        if (!i_rst_n) begin
            foreach (stored_keys[i]) stored_keys[i] = '0;
            awaited_results.delete();
            mismatches   = 0;
            checked      = 0;
            duplicates   = 0;
            full_reports = 0;
        end else begin
            if (i_pop && !i_empty) begin
                checked++;
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: result beat with nothing expected, status %0d slot %0d",
                                 $time, i_result.status, i_result.slot);
                    end
                end else begin
                    wanted = awaited_results.pop_front();
                    if (wanted.status != i_result.status || wanted.slot != i_result.slot) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: expected status %0d slot %0d, got status %0d slot %0d",
                                     $time, wanted.status, wanted.slot,
                                     i_result.status, i_result.slot);
                        end
                    end else if (wanted.status == ST_DUPLICATE) begin
                        duplicates++;
                    end else if (wanted.status == ST_FULL) begin
                        full_reports++;
                    end
                end
            end
            if (i_push && !i_full) begin
                awaited_results.push_back(probe_and_record(i_item));
            end
        end
        o_mismatches   <= mismatches;
        o_pending      <= awaited_results.size();
        o_checked      <= checked;
        o_duplicates   <= duplicates;
        o_full_reports <= full_reports;
    end

endmodule

// ----- tb/testbench.sv -----
module testbench;
    import dkd_pkg::*;

    localparam int SLOTS        = TABLE_SLOTS_DEF;
    localparam int HOME_W       = $clog2(SLOTS);
    localparam int RANDOM_BEATS = 600;
    localparam int POOL_CAP     = 64;
    localparam int CYCLE_LIMIT  = 10000000;

    logic    clk;
    logic    rst_n = 1'b0;
    logic    push  = 1'b0;
    logic    pop   = 1'b0;
    logic    calm  = 1'b0;
    t_item   item  = '0;
    logic    full;
    logic    empty;
    t_result result;

    int mismatches;
    int pending;
    int checked;
    int duplicates;
    int full_reports;
    int cycles     = 0;
    int beats_sent = 0;

    logic [KEY_W-1:0] key_pool [$];

    duplicate_key_detector_unit u_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .push     (push),
        .i_item   (item),
        .full     (full),
        .empty    (empty),
        .pop      (pop),
        .o_result (result)
    );

    key_set_monitor #(
        .SLOTS (SLOTS)
    ) u_monitor (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_push         (push),
        .i_full         (full),
        .i_item         (item),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_result       (result),
        .o_mismatches   (mismatches),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_duplicates   (duplicates),
        .o_full_reports (full_reports)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Cycle limit reached with %0d results still expected.", pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk) begin
        pop <= calm || ($urandom_range(99) >= 35);
    end

    // Keeps bits 14:4 of the key, which alone decide the home slot, and randomises the rest.
    function automatic logic [KEY_W-1:0] key_with_home(logic [HOME_W-1:0] tag);
        logic [KEY_W-1:0] key;
        key = {$urandom, $urandom};
        key[HOME_W+3:4] = tag;
        if (key == '0) begin
            key[KEY_W-1] = 1'b1;
        end
        return key;
    endfunction

    function automatic logic [HOME_W-1:0] tag_for_home(logic [HOME_W-1:0] home);
        logic [HOME_W-1:0] tag;
        tag = '0;
        for (int t = 0; t < SLOTS; t++) begin
            if (HOME_W'(t * HASH_MULT) == home) begin
                tag = HOME_W'(t);
            end
        end
        return tag;
    endfunction

    task automatic send_beat(input t_action act, input logic [KEY_W-1:0] key);
        while (!calm && $urandom_range(99) < 35) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= '{act, key};
        do @(posedge clk); while (full);
        beats_sent++;
    endtask

    initial begin
        logic [KEY_W-1:0]  pick;
        logic [KEY_W-1:0]  wrap_key;
        logic [HOME_W-1:0] wrap_tag;
        int                choice;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        send_beat(ACT_INSERT, '0);
        send_beat(ACT_CLEAR, '1);
        send_beat(ACT_INSERT, '1);
        send_beat(ACT_INSERT, '1);
        send_beat(ACT_INSERT, 64'h1);
        send_beat(ACT_INSERT, 64'h10);
        send_beat(ACT_INSERT, 64'hF);
        send_beat(ACT_INSERT, 64'h8000_0000_0000_0000);
        send_beat(ACT_INSERT, 64'hF);
        send_beat(ACT_INSERT, 64'h8000_0000_0000_0000);
        send_beat(ACT_INSERT, 64'h5555_5555_5555_5555);
        send_beat(ACT_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
        send_beat(ACT_CLEAR, '0);
        send_beat(ACT_INSERT, 64'h1);
        send_beat(ACT_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);

        // Three keys share the last slot as home, so the later ones wrap round to the start.
        send_beat(ACT_CLEAR, {$urandom, $urandom});
        wrap_tag = tag_for_home(HOME_W'(SLOTS - 1));
        pick     = key_with_home(wrap_tag);
        send_beat(ACT_INSERT, pick);
        wrap_key = key_with_home(wrap_tag);
        send_beat(ACT_INSERT, wrap_key);
        send_beat(ACT_INSERT, key_with_home(wrap_tag));
        send_beat(ACT_INSERT, wrap_key);
        send_beat(ACT_INSERT, pick);
        send_beat(ACT_INSERT, '0);
        send_beat(ACT_CLEAR, {$urandom, $urandom});

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            calm   <= (n >= 200 && n < 350);
            choice = $urandom_range(99);
            if (choice < 2) begin
                send_beat(ACT_CLEAR, {$urandom, $urandom});
            end else if (choice < 8) begin
                send_beat(ACT_INSERT, '0);
            end else begin
                if (key_pool.size() == 0 || choice >= 70) begin
                    pick = {$urandom, $urandom};
                end else begin
                    pick = key_pool[$urandom_range(key_pool.size() - 1)];
                    if (choice >= 40) begin
                        pick = key_with_home(pick[HOME_W+3:4]);
                    end
                end
                send_beat(ACT_INSERT, pick);
                key_pool.push_back(pick);
                if (key_pool.size() > POOL_CAP) begin
                    void'(key_pool.pop_front());
                end
            end
        end
        push <= 1'b0;
        calm <= 1'b0;

        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d beats: directed cases, a probe chain wrapping past the last slot and %0d random beats.",
                 beats_sent, RANDOM_BEATS);
        $display("Checked %0d results, with %0d duplicates and %0d full-table reports.",
                 checked, duplicates, full_reports);
        if (pending != 0) begin
            $display("%0d expected results never arrived.", pending);
        end
        if (mismatches == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
